@@ rtl/core/hcm_pkg.sv @@
// ----------------------------------------------------------------------------
// hcm_pkg
// shared constants and types of the hypercube curve mapper
// ----------------------------------------------------------------------------
package hcm_pkg;

  localparam int DIMS      = 4;
  localparam int DENSITY   = 10;
  localparam int FRAC_BITS = DIMS * DENSITY;
  localparam int POS_W     = FRAC_BITS + 1;
  localparam int COORD_W   = DENSITY + 1;
  localparam int IDX_W     = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int DIM_OUT_W = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t coord_arr_t [DIMS];

  // carried between levels: running sign vector (1 = negative) and node index
  typedef struct packed {
    logic [DIMS-1:0]  sw_neg;
    logic [IDX_W-1:0] node_it;
  } lvl_state_t;

endpackage

@@ rtl/core/hcm_level_unit.sv @@
// ----------------------------------------------------------------------------
// hcm_level_unit
// one evolvent level: digit decode, entry swap, renumbering, sign update and
// the per-coordinate add or subtract of the level step
// ----------------------------------------------------------------------------
module hcm_level_unit import hcm_pkg::*; (
  input  logic [DIMS-1:0] digit,
  input  lvl_state_t      state_i,
  input  coord_arr_t      acc_i,
  input  coord_t          step,
  output lvl_state_t      state_o,
  output coord_arr_t      acc_o
);

  logic [DIMS:0]    bx;
  logic [DIMS-1:0]  su_neg;
  logic [DIMS-1:0]  sv_neg;
  logic [DIMS-1:0]  su_sw;
  logic [DIMS-1:0]  sv_sw;
  logic [DIMS-1:0]  su_fin;
  logic [IDX_W-1:0] node;
  logic [IDX_W-1:0] node_rn;
  logic             flip_neg;
  logic [DIMS-1:0]  low_mask;

  // digit to node and sign vectors
  always_comb begin
    bx       = {1'b0, digit};
    node     = '0;
    flip_neg = 1'b0;
    su_neg   = '0;
    sv_neg   = '0;
    low_mask = '0;
    if (digit == '0) begin
      su_neg = '1;
      sv_neg = '1;
      node   = IDX_W'(DIMS - 1);
    end else if (digit == '1) begin
      su_neg        = '1;
      sv_neg        = '1;
      su_neg[0]     = 1'b0;
      sv_neg[0]     = 1'b0;
      sv_neg[DIMS-1] = 1'b0;
      node          = IDX_W'(DIMS - 1);
    end else begin
      for (int k = 0; k < DIMS; k++) begin
        low_mask  = ~({DIMS{1'b1}} << (DIMS - 1 - k));
        su_neg[k] = ~(bx[DIMS-1-k] ^ bx[DIMS-k]);
        if (k < DIMS - 1) begin
          if (!bx[DIMS-1-k] && ((digit & low_mask) == low_mask)) begin
            node     = IDX_W'(k);
            flip_neg = 1'b0;
          end else if (bx[DIMS-1-k] && ((digit & low_mask) == '0)) begin
            node     = IDX_W'(k);
            flip_neg = 1'b1;
          end
        end
      end
      sv_neg         = su_neg;
      sv_neg[node]   = sv_neg[node] ^ flip_neg;
      sv_neg[DIMS-1] = ~sv_neg[DIMS-1];
    end
  end

  // swap entry 0 with the carried node entry, renumber, update signs and add or subtract the step
  always_comb begin
    for (int k = 0; k < DIMS; k++) begin
      if (k == 0) begin
        su_sw[k] = su_neg[state_i.node_it];
        sv_sw[k] = sv_neg[state_i.node_it];
      end else if (IDX_W'(k) == state_i.node_it) begin
        su_sw[k] = su_neg[0];
        sv_sw[k] = sv_neg[0];
      end else begin
        su_sw[k] = su_neg[k];
        sv_sw[k] = sv_neg[k];
      end
    end
    if (node == '0) begin
      node_rn = state_i.node_it;
    end else if (node == state_i.node_it) begin
      node_rn = '0;
    end else begin
      node_rn = node;
    end
    su_fin         = su_sw ^ state_i.sw_neg;
    state_o.sw_neg = state_i.sw_neg ^ ~sv_sw;
    state_o.node_it = node_rn;
    for (int k = 0; k < DIMS; k++) begin
      acc_o[k] = su_fin[k] ? (acc_i[k] - step) : (acc_i[k] + step);
    end
  end

endmodule

@@ rtl/core/hcm_emitter.sv @@
// ----------------------------------------------------------------------------
// hcm_emitter
// holds one finished point and sends its coordinates one per transaction
// ----------------------------------------------------------------------------
module hcm_emitter import hcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  coord_arr_t           coords,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DIM_OUT_W-1:0] out_dim_index,
  output logic [COORD_W-1:0]   out_coord_value,
  output logic                 out_last
);

  coord_arr_t       buf_r;
  logic             busy_r;
  logic [IDX_W-1:0] cnt_r;
  logic             is_last;

  assign is_last         = (cnt_r == IDX_W'(DIMS - 1));
  assign free            = !busy_r;
  assign out_valid       = busy_r;
  assign out_dim_index   = DIM_OUT_W'(cnt_r);
  assign out_coord_value = buf_r[cnt_r];
  assign out_last        = is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= coords;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r && out_ready) begin
      if (is_last) begin
        busy_r <= 1'b0;
        cnt_r  <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/hypercube_curve_mapper.sv @@
// ----------------------------------------------------------------------------
// hypercube_curve_mapper
// maps a curve position to a point of the hypercube on a peano-type evolvent
// ----------------------------------------------------------------------------
// an accepted position runs the level loop through the shared level unit,
// one level per cycle, then waits until the output buffer is free; the
// buffer sends one coordinate per cycle while out_ready is high; no new
// position is taken before the point is handed to the buffer, but emission
// of a point overlaps the next position while the output buffer drains in time
// reset: synchronous active-low, clears the sequencer and the output buffer
// state; no clearing pass
module hypercube_curve_mapper import hcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [POS_W-1:0]     in_position,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DIM_OUT_W-1:0] out_dim_index,
  output logic [COORD_W-1:0]   out_coord_value,
  output logic                 out_last
);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [FRAC_BITS-1:0] pos_r;       // remaining digits, next one at the top
  logic                 full_r;      // position at or above one
  logic [DENSITY-1:0]   step_r;      // one-hot level weight, halves per level
  lvl_state_t           lvl_r;
  lvl_state_t           lvl_nxt;
  coord_arr_t           acc_r;
  coord_arr_t           acc_nxt;
  logic [DIMS-1:0]      digit;
  logic                 accept;
  logic                 last_level;
  logic                 em_free;
  logic                 em_load;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign last_level = step_r[0];
  assign em_load    = (state_r == S_HOLD) && em_free;

  // all ones digit when the position is at or above one
  assign digit = full_r ? {DIMS{1'b1}} : pos_r[FRAC_BITS-1 -: DIMS];

  // shared level unit, reused once per level
  hcm_level_unit u_level (
    .digit   (digit),
    .state_i (lvl_r),
    .acc_i   (acc_r),
    .step    ({1'b0, step_r}),
    .state_o (lvl_nxt),
    .acc_o   (acc_nxt)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (last_level) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (em_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers: sums start at zero, signs positive, node index zero
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r          <= in_position[FRAC_BITS-1:0];
      full_r         <= in_position[FRAC_BITS];
      step_r         <= {1'b1, {(DENSITY-1){1'b0}}};
      lvl_r.sw_neg   <= '0;
      lvl_r.node_it  <= '0;
      for (int k = 0; k < DIMS; k++) begin
        acc_r[k] <= '0;
      end
    end else if (state_r == S_RUN) begin
      pos_r  <= pos_r << DIMS;
      step_r <= step_r >> 1;
      lvl_r  <= lvl_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // output buffer and serialiser
  hcm_emitter u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (em_load),
    .coords          (acc_r),
    .free            (em_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dim_index   (out_dim_index),
    .out_coord_value (out_coord_value),
    .out_last        (out_last)
  );

  // an accepted transaction always starts the level loop
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_RUN))
    else $error("accepted position did not start the level loop");

  // the level weight stays one-hot while levels run
  a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> $onehot(step_r))
    else $error("level weight not one-hot");

  // a finished point never overwrites one still being sent
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    em_load |-> !out_valid)
    else $error("output buffer loaded while busy");

  // no new position is taken while the loop is running or holding a point
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RUN) || (state_r == S_HOLD)) |-> !in_ready)
    else $error("input ready while busy");

endmodule

@@ tb/hcm_checker.sv @@
// ----------------------------------------------------------------------------
// hcm_checker
// watches both channels of the curve mapper, predicts each point's
// coordinates from the accepted position and compares them in order
// ----------------------------------------------------------------------------
module hcm_checker import hcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [POS_W-1:0]     in_position,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [DIM_OUT_W-1:0] out_dim_index,
  input  logic [COORD_W-1:0]   out_coord_value,
  input  logic                 out_last,
  output int                   fail_count,
  output int                   pending,
  output int                   coords_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DIM_OUT_W-1:0] dim;
    logic [COORD_W-1:0]   value;
    logic                 last_flag;
  } coord_item_t;

  coord_item_t coord_q[$];
  int mismatches = 0;
  int checked    = 0;

  assign fail_count     = mismatches;
  assign coords_checked = checked;

  // node index and sign vectors of one digit, signs held as 1 = negative
  function automatic void digit_signs(input logic [DIMS-1:0] dig, output int node,
                                      output logic [DIMS-1:0] u_neg,
                                      output logic [DIMS-1:0] v_neg);
    int   rest;
    int   half;
    int   k;
    logic prev_neg;
    logic cur_neg;
    logic flip_neg;
    rest     = dig;
    prev_neg = 1'b1;
    flip_neg = 1'b0;
    node     = 0;
    u_neg    = '1;
    v_neg    = '1;
    if (dig == '0) begin
      node = DIMS - 1;
    end else if (dig == '1) begin
      u_neg[0]      = 1'b0;
      v_neg[0]      = 1'b0;
      v_neg[DIMS-1] = 1'b0;
      node          = DIMS - 1;
    end else begin
      for (k = 0; k < DIMS; k++) begin
        half = 1 << (DIMS - 1 - k);
        if (rest < half) begin
          cur_neg = 1'b1;
          if (rest == half - 1 && rest != 0) begin
            node     = k;
            flip_neg = 1'b0;
          end
        end else begin
          if (rest == half && rest != 1) begin
            node     = k;
            flip_neg = 1'b1;
          end
          rest    = rest - half;
          cur_neg = 1'b0;
        end
        u_neg[k] = ~(prev_neg ^ cur_neg);
        prev_neg = cur_neg;
      end
      v_neg         = u_neg;
      v_neg[node]   = v_neg[node] ^ flip_neg;
      v_neg[DIMS-1] = ~v_neg[DIMS-1];
    end
  endfunction

  // walks all levels of one position and queues its coordinates
  function automatic void predict_point(input logic [POS_W-1:0] pos);
    logic [DIMS-1:0] dig;
    logic [DIMS-1:0] u_neg;
    logic [DIMS-1:0] v_neg;
    logic [DIMS-1:0] w_neg;
    logic            t;
    int              node;
    int              carried;
    int              step;
    int              lvl;
    int              k;
    int              acc [DIMS];
    coord_item_t     item;
    w_neg   = '0;
    carried = 0;
    for (k = 0; k < DIMS; k++) acc[k] = 0;
    for (lvl = 0; lvl < DENSITY; lvl++) begin
      // at or above one every digit is all ones
      if (pos[FRAC_BITS]) dig = '1;
      else dig = DIMS'(pos >> (DIMS * (DENSITY - 1 - lvl)));
      digit_signs(dig, node, u_neg, v_neg);
      t              = u_neg[0];
      u_neg[0]       = u_neg[carried];
      u_neg[carried] = t;
      t              = v_neg[0];
      v_neg[0]       = v_neg[carried];
      v_neg[carried] = t;
      if (node == 0) node = carried;
      else if (node == carried) node = 0;
      carried = node;
      step  = 1 << (DENSITY - 1 - lvl);
      u_neg = u_neg ^ w_neg;
      w_neg = w_neg ^ ~v_neg;
      for (k = 0; k < DIMS; k++) acc[k] += u_neg[k] ? -step : step;
    end
    for (k = 0; k < DIMS; k++) begin
      item.dim       = DIM_OUT_W'(k);
      item.value     = COORD_W'(acc[k]);
      item.last_flag = (k == DIMS - 1);
      coord_q.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    coord_item_t want;
    if (!rst_n) begin
      coord_q.delete();
      pending <= 0;
    end else begin
      if (in_valid && in_ready) predict_point(in_position);
      if (out_valid && out_ready) begin
        if (coord_q.size() == 0) begin
          $display("%0t ns: unexpected coordinate, expected none, got dim %0d value %0d last %0b",
                   $time, out_dim_index, $signed(out_coord_value), out_last);
          mismatches++;
        end else begin
          want = coord_q.pop_front();
          checked++;
          if (out_dim_index !== want.dim) begin
            $display("%0t ns: dim_index expected %0d got %0d", $time, want.dim, out_dim_index);
            mismatches++;
          end
          if (out_coord_value !== want.value) begin
            $display("%0t ns: coord_value of dim %0d expected %0d got %0d", $time, want.dim,
                     $signed(want.value), $signed(out_coord_value));
            mismatches++;
          end
          if (out_last !== want.last_flag) begin
            $display("%0t ns: last of dim %0d expected %0b got %0b", $time, want.dim,
                     want.last_flag, out_last);
            mismatches++;
          end
        end
      end
      pending <= coord_q.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// drives the curve mapper with directed and random positions under bursty
// input and a stalling receiver; a checker beside the block does the scoring
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hcm_pkg::*;

  // no transaction on either side for this long means the block is stuck;
  // the worst honest stretch is a sender gap plus the level loop plus a
  // long run of stalls
  localparam int IDLE_LIMIT       = 2000;
  // quiet time at the end: a full point's latency plus its emission
  localparam int SETTLE_CYCLES    = DENSITY + 2 + DIMS + 8;
  localparam int RANDOM_POSITIONS = 237;

  // receiver behaviour, switched to a random mode when the mode time runs out
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic [POS_W-1:0]     in_position = '0;
  logic                 out_ready   = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [DIM_OUT_W-1:0] out_dim_index;
  logic [COORD_W-1:0]   out_coord_value;
  logic                 out_last;

  int       fail_count;
  int       pending;
  int       coords_checked;
  int       positions_sent = 0;
  int       full_sent      = 0;
  int       burst_left     = 0;
  int       idle_cycles    = 0;
  int       mode_left      = 0;
  int       phase          = 0;
  rx_mode_t rx_mode        = RX_OPEN;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  hypercube_curve_mapper dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dim_index   (out_dim_index),
    .out_coord_value (out_coord_value),
    .out_last        (out_last)
  );

  hcm_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dim_index   (out_dim_index),
    .out_coord_value (out_coord_value),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending         (pending),
    .coords_checked  (coords_checked)
  );

  // one position per transaction; a new burst starts after a random gap so
  // that the gaps land on every phase of the level loop
  task automatic send_position(input logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 15);
      // mostly short bursts, now and then a long one with no idling at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_position <= pos;
    positions_sent++;
    if (pos[FRAC_BITS]) full_sent++;
    // held until the edge that sees valid and ready together
    do @(posedge clk); while (!in_ready);
  endtask

  // sender holds off until every predicted coordinate has come out
  task automatic wait_for_drain();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // most positions are plain and uniform, some sit at or above one, and the
  // rest are built digit by digit from the corner cases of the node rules
  function automatic logic [POS_W-1:0] random_position();
    logic [POS_W-1:0] pos;
    logic [DIMS-1:0]  dig;
    int               kind;
    int               lvl;
    kind = $urandom_range(0, 9);
    pos  = POS_W'({$urandom, $urandom});
    if (kind < 6) begin
      pos[FRAC_BITS] = 1'b0;
    end else if (kind == 6) begin
      // saturated codes, a quarter of them exactly one
      if ($urandom_range(0, 3) == 0) pos = '0;
      pos[FRAC_BITS] = 1'b1;
    end else begin
      pos = '0;
      for (lvl = 0; lvl < DENSITY; lvl++) begin
        case ($urandom_range(0, 4))
          0: begin
            dig = '0;
          end
          1: begin
            dig = '1;
          end
          2: begin
            dig = DIMS'(1) << $urandom_range(0, DIMS - 1);
          end
          3: begin
            dig = (DIMS'(1) << $urandom_range(1, DIMS - 1)) - DIMS'(1);
          end
          default: begin
            dig = DIMS'($urandom);
          end
        endcase
        pos = (pos << DIMS) | POS_W'(dig);
      end
    end
    return pos;
  endfunction

  // receiver: open, coin-flip, mostly stalled, or a fixed 3-of-5 rhythm
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(16, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN: begin
        out_ready <= 1'b1;
      end
      RX_COIN: begin
        out_ready <= ($urandom_range(0, 1) == 1);
      end
      RX_SPARSE: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready <= (phase % 5) < 3;
      end
    endcase
    phase <= phase + 1;
  end

  // watchdog on transaction activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [POS_W-1:0] pos;
    int               d;
    int               lvl;
    int               i;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero, exactly one, the largest code, just below one,
    // just above one
    send_position('0);
    pos            = '0;
    pos[FRAC_BITS] = 1'b1;
    send_position(pos);
    send_position('1);
    send_position({1'b0, {FRAC_BITS{1'b1}}});
    pos[0] = 1'b1;
    send_position(pos);

    // every digit value repeated on all levels, so each node rule and the
    // swap with the carried node are hit level after level
    for (d = 0; d < (1 << DIMS); d++) begin
      pos = '0;
      for (lvl = 0; lvl < DENSITY; lvl++) pos = (pos << DIMS) | POS_W'(d);
      send_position(pos);
    end

    // alternating bit patterns and their complement
    pos = '0;
    for (lvl = 0; lvl < FRAC_BITS; lvl++) pos[lvl] = lvl[0];
    send_position(pos);
    send_position({1'b0, ~pos[FRAC_BITS-1:0]});

    wait_for_drain();

    // random part, with two more full drains along the way
    for (i = 0; i < RANDOM_POSITIONS; i++) begin
      send_position(random_position());
      if (i == RANDOM_POSITIONS / 3 || i == 2 * RANDOM_POSITIONS / 3) wait_for_drain();
    end
    in_valid <= 1'b0;

    // let the last points drain, then watch for stray results
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d positions mapped, %0d of them at or above one", positions_sent, full_sent);
    $display("%0d coordinates compared against bursty input and a stalling receiver",
             coords_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
